// File: hw/rtl/pfd_pkg.sv
package pfd_pkg;

    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int SUM_W      = 32;
    localparam int DER_W      = 48;
    localparam int ACC_W      = 50;
    localparam int MA_W       = 34;
    localparam int MB_W       = 18;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [14:0] OUT_LIMIT_RESET = 15'h7FFF;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KD_D,
        ST_T1,
        ST_DLO,
        ST_DHI,
        ST_KP_E,
        ST_KI_I,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MS_KD_D,
        MS_T1,
        MS_DLO,
        MS_DHI,
        MS_KP_E,
        MS_KI_I
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_T1,
        ACC_LO,
        ACC_DERIV,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     integ_upd;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic signed [15:0] deriv_gain;
        logic [15:0]        smoothing;
        logic [30:0]        integ_limit;
        logic [14:0]        output_limit;
    } cfg_t;

endpackage

// File: hw/rtl/pid_filtered_derivative.sv
// Positional PID controller with a low-pass filtered derivative term. Each input
// transaction is either a compute step (reference, feedback) or a clear command, and
// yields exactly one result transaction (drive, saturated). A compute step goes
// through KD_D, T1, DLO, DHI, KP_E, KI_I and SUM to DONE, where its result is loaded:
// the six products (kd*d, times (1-alpha), two halves of alpha*deriv, kp*e, ki*integ)
// go one after another through a single registered 34x18 multiplier. The controller
// then returns to idle. A clear command goes from idle straight to the done state and
// loads its result there. A new transaction is accepted once the controller is back
// in idle, even while the previous result is still stalled at the output register;
// the following result then waits in the done state while the output stall holds.
// Gains are Q8.8, smoothing is Q0.16, and registers must be written only while the
// block is idle.
module pid_filtered_derivative
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic signed [15:0]                reference,
    input  logic signed [15:0]                feedback,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                drive,
    output logic                              saturated
);

    pfd_pkg::cfg_t cfg;
    pfd_pkg::cmd_t cmd;

    pfd_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    pfd_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .reference (reference),
        .feedback  (feedback),
        .drive     (drive),
        .saturated (saturated)
    );

endmodule

// File: hw/rtl/pfd_regs.sv
module pfd_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pfd_pkg::cfg_t                    cfg
);

    pfd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain    <= '0;
            cfg_reg.integ_gain   <= '0;
            cfg_reg.deriv_gain   <= '0;
            cfg_reg.smoothing    <= '0;
            cfg_reg.integ_limit  <= '0;
            cfg_reg.output_limit <= pfd_pkg::OUT_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pfd_pkg::REG_PROP_GAIN:    cfg_reg.prop_gain    <= cfg_data[15:0];
                pfd_pkg::REG_INTEG_GAIN:   cfg_reg.integ_gain   <= cfg_data[15:0];
                pfd_pkg::REG_DERIV_GAIN:   cfg_reg.deriv_gain   <= cfg_data[15:0];
                pfd_pkg::REG_SMOOTHING:    cfg_reg.smoothing    <= cfg_data[15:0];
                pfd_pkg::REG_INTEG_LIMIT:  cfg_reg.integ_limit  <= cfg_data[30:0];
                pfd_pkg::REG_OUTPUT_LIMIT: cfg_reg.output_limit <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/pfd_ctrl.sv
module pfd_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           operation,
    output logic           out_valid,
    input  logic           out_stall,
    output pfd_pkg::cmd_t  cmd
);

    pfd_pkg::state_t state_reg;
    pfd_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd.load          = 1'b0;
        cmd.clear         = 1'b0;
        cmd.integ_upd     = 1'b0;
        cmd.mul_sel       = pfd_pkg::MS_KD_D;
        cmd.acc_op        = pfd_pkg::ACC_HOLD;
        cmd.out_load      = 1'b0;

        case (state_reg)
            pfd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = pfd_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = pfd_pkg::ST_KD_D;
                    end
                end
            end
            pfd_pkg::ST_KD_D:
            begin
                cmd.mul_sel   = pfd_pkg::MS_KD_D;
                cmd.integ_upd = 1'b1;
                state_next    = pfd_pkg::ST_T1;
            end
            pfd_pkg::ST_T1:
            begin
                cmd.mul_sel = pfd_pkg::MS_T1;
                state_next  = pfd_pkg::ST_DLO;
            end
            pfd_pkg::ST_DLO:
            begin
                cmd.mul_sel = pfd_pkg::MS_DLO;
                cmd.acc_op  = pfd_pkg::ACC_T1;
                state_next  = pfd_pkg::ST_DHI;
            end
            pfd_pkg::ST_DHI:
            begin
                cmd.mul_sel = pfd_pkg::MS_DHI;
                cmd.acc_op  = pfd_pkg::ACC_LO;
                state_next  = pfd_pkg::ST_KP_E;
            end
            pfd_pkg::ST_KP_E:
            begin
                cmd.mul_sel = pfd_pkg::MS_KP_E;
                cmd.acc_op  = pfd_pkg::ACC_DERIV;
                state_next  = pfd_pkg::ST_KI_I;
            end
            pfd_pkg::ST_KI_I:
            begin
                cmd.mul_sel = pfd_pkg::MS_KI_I;
                cmd.acc_op  = pfd_pkg::ACC_ADD;
                state_next  = pfd_pkg::ST_SUM;
            end
            pfd_pkg::ST_SUM:
            begin
                cmd.acc_op = pfd_pkg::ACC_ADD;
                state_next = pfd_pkg::ST_DONE;
            end
            pfd_pkg::ST_DONE:
            begin
                // wait here only while the previous result is still stalled
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall  = (state_reg != pfd_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/pfd_dp.sv
module pfd_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  pfd_pkg::cmd_t       cmd,
    input  pfd_pkg::cfg_t       cfg,
    input  logic signed [15:0]  reference,
    input  logic signed [15:0]  feedback,
    output logic signed [15:0]  drive,
    output logic                saturated
);

    localparam int ERR_W  = pfd_pkg::ERR_W;
    localparam int DIFF_W = pfd_pkg::DIFF_W;
    localparam int SUM_W  = pfd_pkg::SUM_W;
    localparam int DER_W  = pfd_pkg::DER_W;
    localparam int ACC_W  = pfd_pkg::ACC_W;
    localparam int MA_W   = pfd_pkg::MA_W;
    localparam int MB_W   = pfd_pkg::MB_W;
    localparam int PROD_W = pfd_pkg::PROD_W;
    localparam int VAL_W  = ACC_W - 8;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [SUM_W-1:0]  err_sum_reg;
    logic signed [SUM_W-1:0]  err_sum_next;
    logic signed [DER_W-1:0]  deriv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [15:0]       drive_reg;
    logic signed [15:0]       drive_next;
    logic                     saturated_reg;
    logic                     saturated_next;

    logic signed [ERR_W-1:0]  err_in;
    logic signed [DIFF_W-1:0] diff_in;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic [16:0]              alpha_cmp;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W:0]    lim_wide;
    logic signed [ACC_W-1:0]  deriv_sum;
    logic signed [DER_W-1:0]  deriv_sat;
    logic signed [VAL_W-1:0]  val;
    logic signed [VAL_W-1:0]  olim_wide;

    assign err_in  = {reference[15], reference} - {feedback[15], feedback};
    assign diff_in = {err_in[ERR_W-1], err_in} - {prev_err_reg[ERR_W-1], prev_err_reg};

    // 65536 - alpha, always in 1..65536
    assign alpha_cmp = 17'h10000 - {1'b0, cfg.smoothing};

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            pfd_pkg::MS_KD_D:
            begin
                mul_a = {{(MA_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                mul_b = {{(MB_W-16){cfg.deriv_gain[15]}}, cfg.deriv_gain};
            end
            pfd_pkg::MS_T1:
            begin
                mul_a = prod_reg[MA_W-1:0];
                mul_b = {{(MB_W-17){1'b0}}, alpha_cmp};
            end
            pfd_pkg::MS_DLO:
            begin
                mul_a = {{(MA_W-17){1'b0}}, deriv_reg[16:0]};
                mul_b = {{(MB_W-16){1'b0}}, cfg.smoothing};
            end
            pfd_pkg::MS_DHI:
            begin
                mul_a = {{(MA_W-(DER_W-17)){deriv_reg[DER_W-1]}}, deriv_reg[DER_W-1:17]};
                mul_b = {{(MB_W-16){1'b0}}, cfg.smoothing};
            end
            pfd_pkg::MS_KP_E:
            begin
                mul_a = {{(MA_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_b = {{(MB_W-16){cfg.prop_gain[15]}}, cfg.prop_gain};
            end
            pfd_pkg::MS_KI_I:
            begin
                mul_a = {{(MA_W-SUM_W){err_sum_reg[SUM_W-1]}}, err_sum_reg};
                mul_b = {{(MB_W-16){cfg.integ_gain[15]}}, cfg.integ_gain};
            end
            default:
            begin
                mul_a = {{(MA_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                mul_b = {{(MB_W-16){cfg.deriv_gain[15]}}, cfg.deriv_gain};
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // integrator with symmetric clamp
    assign sum_wide = {err_sum_reg[SUM_W-1], err_sum_reg}
                    + {{(SUM_W+1-ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign lim_wide = {2'b00, cfg.integ_limit};

    always_comb
    begin
        if (sum_wide < -lim_wide)
            err_sum_next = -lim_wide[SUM_W-1:0];
        else if (sum_wide > lim_wide)
            err_sum_next = lim_wide[SUM_W-1:0];
        else
            err_sum_next = sum_wide[SUM_W-1:0];
    end

    // a*deriv >> 16 == 2*(a*hi) + (a*lo >> 16) with hi = deriv[47:17], lo = deriv[16:0]
    assign deriv_sum = acc_reg + {prod_reg[DER_W-1], prod_reg[DER_W-1:0], 1'b0};

    always_comb
    begin
        if (deriv_sum[ACC_W-1:DER_W-1] == {(ACC_W-DER_W+1){deriv_sum[ACC_W-1]}})
            deriv_sat = deriv_sum[DER_W-1:0];
        else if (deriv_sum[ACC_W-1])
            deriv_sat = {1'b1, {(DER_W-1){1'b0}}};
        else
            deriv_sat = {1'b0, {(DER_W-1){1'b1}}};
    end

    always_comb
    begin
        case (cmd.acc_op)
            pfd_pkg::ACC_T1:
                acc_next = {{(ACC_W-34){prod_reg[49]}}, prod_reg[49:16]};
            pfd_pkg::ACC_LO:
                acc_next = acc_reg + {{(ACC_W-17){1'b0}}, prod_reg[32:16]};
            pfd_pkg::ACC_DERIV:
                acc_next = {{(ACC_W-DER_W){deriv_sat[DER_W-1]}}, deriv_sat};
            pfd_pkg::ACC_ADD:
                acc_next = acc_reg + prod_reg[ACC_W-1:0];
            default:
                acc_next = acc_reg;
        endcase
    end

    // output shift and clamp
    assign val       = acc_reg[ACC_W-1:8];
    assign olim_wide = {{(VAL_W-15){1'b0}}, cfg.output_limit};

    always_comb
    begin
        if (val > olim_wide)
        begin
            drive_next     = {1'b0, cfg.output_limit};
            saturated_next = 1'b1;
        end
        else if (val < -olim_wide)
        begin
            drive_next     = -{1'b0, cfg.output_limit};
            saturated_next = 1'b1;
        end
        else
        begin
            drive_next     = val[15:0];
            saturated_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            err_sum_reg  <= '0;
            deriv_reg    <= '0;
        end
        else if (cmd.clear)
        begin
            prev_err_reg <= '0;
            err_sum_reg  <= '0;
            deriv_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
                prev_err_reg <= err_in;
            if (cmd.integ_upd)
                err_sum_reg <= err_sum_next;
            if (cmd.acc_op == pfd_pkg::ACC_DERIV)
                deriv_reg <= deriv_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load)
        begin
            err_reg  <= err_in;
            diff_reg <= diff_in;
        end
        if (cmd.clear)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
        if (cmd.out_load)
        begin
            drive_reg     <= drive_next;
            saturated_reg <= saturated_next;
        end
    end

    assign drive     = drive_reg;
    assign saturated = saturated_reg;

endmodule

// File: bench/tb_pid_filtered_derivative.sv
module tb_pid_filtered_derivative;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_CLEAR   = 1'b1
    } op_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               saturated;
    } ctrl_out_t;

    typedef struct {
        row_kind_t                        kind;
        logic [pfd_pkg::CFG_IDX_W-1:0]    idx;
        logic [pfd_pkg::CFG_DATA_W-1:0]   data;
        op_t                              op;
        logic signed [15:0]               r;
        logic signed [15:0]               f;
        bit                               typed;
        ctrl_out_t                        want;
    } stim_row_t;

    // index past the last register, writes must be dropped
    localparam logic [pfd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint DERIV_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DERIV_MIN   = -DERIV_MAX - 1;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     RANDOM_ITEMS = 1350;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     HOLD_CYCLES  = 300;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           operation = 1'b0;
    logic signed [15:0]             reference = '0;
    logic signed [15:0]             feedback = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [15:0]             drive;
    logic                           saturated;

    pid_filtered_derivative DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .reference (reference),
        .feedback  (feedback),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .saturated (saturated)
    );

    always #1 clk = ~clk;

    // controller copy kept alongside the block
    pfd_pkg::cfg_t      ctrl_cfg;
    logic signed [16:0] last_err;
    longint             integ_sum;
    longint             deriv_term;

    ctrl_out_t  drive_q[$];
    stim_row_t  plan[$];
    int         errors = 0;
    int         items_sent = 0;
    int         cycles = 0;
    bit         steady = 1'b0;
    bit         hold_done = 1'b0;
    int         hold_left = 0;

    function automatic void apply_reg(logic [pfd_pkg::CFG_IDX_W-1:0] idx,
                                      logic [pfd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            pfd_pkg::REG_PROP_GAIN:    ctrl_cfg.prop_gain    = data[15:0];
            pfd_pkg::REG_INTEG_GAIN:   ctrl_cfg.integ_gain   = data[15:0];
            pfd_pkg::REG_DERIV_GAIN:   ctrl_cfg.deriv_gain   = data[15:0];
            pfd_pkg::REG_SMOOTHING:    ctrl_cfg.smoothing    = data[15:0];
            pfd_pkg::REG_INTEG_LIMIT:  ctrl_cfg.integ_limit  = data[30:0];
            pfd_pkg::REG_OUTPUT_LIMIT: ctrl_cfg.output_limit = data[14:0];
            default: ;
        endcase
    endfunction

    function automatic ctrl_out_t pid_step(op_t op, logic signed [15:0] r,
                                           logic signed [15:0] f);
        longint    e, d, t1, t2, nd, lim, acc, val, olim;
        ctrl_out_t res;
        res = '0;
        if (op == OP_CLEAR)
        begin
            last_err   = '0;
            integ_sum  = 0;
            deriv_term = 0;
            return res;
        end
        e = longint'(r) - longint'(f);
        d = e - longint'(last_err);
        last_err = e[16:0];

        t1 = longint'(ctrl_cfg.deriv_gain) * d
           * (64'sd65536 - longint'(ctrl_cfg.smoothing));
        t2 = longint'(ctrl_cfg.smoothing) * deriv_term;
        nd = (t1 >>> 16) + (t2 >>> 16);
        if (nd > DERIV_MAX)
            nd = DERIV_MAX;
        if (nd < DERIV_MIN)
            nd = DERIV_MIN;
        deriv_term = nd;

        lim = longint'(ctrl_cfg.integ_limit);
        integ_sum = integ_sum + e;
        if (integ_sum < -lim)
            integ_sum = -lim;
        else if (integ_sum > lim)
            integ_sum = lim;

        acc = longint'(ctrl_cfg.prop_gain) * e
            + longint'(ctrl_cfg.integ_gain) * integ_sum + nd;
        val = acc >>> 8;
        olim = longint'(ctrl_cfg.output_limit);
        if (val > olim)
        begin
            val = olim;
            res.saturated = 1'b1;
        end
        else if (val < -olim)
        begin
            val = -olim;
            res.saturated = 1'b1;
        end
        res.drive = val[15:0];
        return res;
    endfunction

    task automatic add_cfg(logic [pfd_pkg::CFG_IDX_W-1:0] idx,
                           logic [pfd_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{kind: ROW_CFG, idx: idx, data: data, op: OP_COMPUTE, r: '0, f: '0,
                typed: 1'b0, want: '0};
        plan.push_back(row);
    endtask

    task automatic add_item(op_t op, logic signed [15:0] r, logic signed [15:0] f,
                            bit typed = 1'b0, logic signed [15:0] d = '0, logic s = 1'b0);
        stim_row_t row;
        row = '{kind: ROW_ITEM, idx: '0, data: '0, op: op, r: r, f: f,
                typed: typed, want: '{drive: d, saturated: s}};
        plan.push_back(row);
    endtask

    // called at a clock edge; leaves in_valid high after acceptance
    task automatic send_item(op_t op, logic signed [15:0] r, logic signed [15:0] f,
                             bit typed, ctrl_out_t want);
        ctrl_out_t predicted;
        cfg_write <= 1'b0;
        while (!steady && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        reference <= r;
        feedback  <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = pid_step(op, r, f);
        drive_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // sender pauses until every result is back, so the block is idle
    task automatic drain();
        in_valid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [pfd_pkg::CFG_IDX_W-1:0] idx,
                             logic [pfd_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg(idx, data);
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'(int'($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int        i;
        int        n;
        int        done_random;
        int        sp;
        int        pv;
        int        m;
        op_t       op;
        logic signed [15:0] r;
        logic signed [15:0] f;
        logic [15:0] sm;
        logic [30:0] il;
        logic [14:0] ol;

        ctrl_cfg = '0;
        ctrl_cfg.output_limit = pfd_pkg::OUT_LIMIT_RESET;
        last_err   = '0;
        integ_sum  = 0;
        deriv_term = 0;

        // directed part; gains all zero after reset
        add_item(OP_COMPUTE, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd0, 1'b0);
        add_item(OP_CLEAR, -16'sd1, -16'sd1, 1'b1, 16'sd0, 1'b0);
        add_cfg(pfd_pkg::REG_PROP_GAIN, 31'd256);
        add_item(OP_COMPUTE, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd32767, 1'b1);
        add_item(OP_COMPUTE, 16'sh8000, 16'sh7FFF, 1'b1, -16'sd32767, 1'b1);
        add_item(OP_COMPUTE, 16'sd100, 16'sd0, 1'b1, 16'sd100, 1'b0);
        add_cfg(pfd_pkg::REG_OUTPUT_LIMIT, 31'd0);
        add_item(OP_COMPUTE, 16'sd5, 16'sd0, 1'b1, 16'sd0, 1'b1);
        add_item(OP_COMPUTE, 16'sd7, 16'sd7, 1'b1, 16'sd0, 1'b0);
        add_cfg(REG_UNUSED, 31'h7FFF_FFFF);
        add_cfg(pfd_pkg::REG_OUTPUT_LIMIT, 31'd32767);
        add_item(OP_COMPUTE, -16'sd3, 16'sd0, 1'b1, -16'sd3, 1'b0);
        add_cfg(pfd_pkg::REG_INTEG_GAIN, 31'd256);
        add_cfg(pfd_pkg::REG_INTEG_LIMIT, 31'd1000);
        add_item(OP_COMPUTE, 16'sd800, 16'sd0);
        add_item(OP_COMPUTE, 16'sd800, 16'sd0);
        // integrator sits above the new limit until the next step
        add_cfg(pfd_pkg::REG_INTEG_LIMIT, 31'd100);
        add_item(OP_COMPUTE, 16'sd0, 16'sd0);
        add_cfg(pfd_pkg::REG_INTEG_LIMIT, 31'd0);
        add_item(OP_COMPUTE, 16'sd50, 16'sd0);
        add_cfg(pfd_pkg::REG_DERIV_GAIN, 31'h8000);
        add_cfg(pfd_pkg::REG_SMOOTHING, 31'hFFFF);
        add_item(OP_COMPUTE, 16'sh8000, 16'sh7FFF);
        add_item(OP_COMPUTE, 16'sh7FFF, 16'sh8000);
        add_cfg(pfd_pkg::REG_SMOOTHING, 31'd0);
        add_item(OP_COMPUTE, 16'sd0, 16'sd0);
        add_cfg(pfd_pkg::REG_INTEG_LIMIT, 31'h7FFF_FFFF);
        add_cfg(pfd_pkg::REG_INTEG_GAIN, 31'h7FFF);
        add_cfg(pfd_pkg::REG_PROP_GAIN, 31'h8000);
        add_cfg(pfd_pkg::REG_DERIV_GAIN, 31'h7FFF);
        add_item(OP_COMPUTE, 16'sh7FFF, 16'sh8000);
        add_item(OP_COMPUTE, 16'sh7FFF, 16'sh8000);
        add_item(OP_CLEAR, 16'sd12345, -16'sd12345, 1'b1, 16'sd0, 1'b0);
        add_item(OP_COMPUTE, 16'sh8000, 16'sh7FFF);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_CFG)
            begin
                if (drive_q.size() != 0 || in_valid)
                    drain();
                write_reg(plan[k].idx, plan[k].data);
            end
            else
            begin
                send_item(plan[k].op, plan[k].r, plan[k].f, plan[k].typed, plan[k].want);
            end
        end

        // random phases, each with a fresh register setting
        done_random = 0;
        sp = 0;
        pv = 0;
        while (done_random < RANDOM_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 3))
                0: sm = 16'h0000;
                1: sm = 16'hFFFF;
                default: sm = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: il = 31'd0;
                1: il = 31'h7FFF_FFFF;
                2: il = 31'($urandom);
                default: il = 31'($urandom_range(0, 200000));
            endcase
            case ($urandom_range(0, 7))
                0: ol = 15'd0;
                1, 2: ol = 15'h7FFF;
                default: ol = 15'($urandom_range(0, 32767));
            endcase
            write_reg(pfd_pkg::REG_PROP_GAIN, 31'(pick_gain()));
            write_reg(pfd_pkg::REG_INTEG_GAIN, 31'(pick_gain()));
            write_reg(pfd_pkg::REG_DERIV_GAIN, 31'(pick_gain()));
            write_reg(pfd_pkg::REG_SMOOTHING, 31'(sm));
            write_reg(pfd_pkg::REG_INTEG_LIMIT, 31'(il));
            write_reg(pfd_pkg::REG_OUTPUT_LIMIT, 31'(ol));
            if ($urandom_range(0, 9) == 0)
                write_reg(3'($urandom_range(6, 7)), 31'($urandom));

            n = $urandom_range(20, 80);
            for (i = 0; i < n; i++)
            begin
                steady = (done_random >= 600 && done_random < 800);
                op = OP_COMPUTE;
                case ($urandom_range(0, 19))
                    0:
                    begin
                        op = OP_CLEAR;
                        r = 16'($urandom);
                        f = 16'($urandom);
                    end
                    1:
                    begin
                        r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        f = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    end
                    2, 3, 4:
                    begin
                        r = 16'($urandom);
                        f = 16'($urandom);
                    end
                    default:
                    begin
                        // a loop settling on a setpoint, with noise
                        if ($urandom_range(0, 15) == 0)
                            sp = int'($urandom_range(0, 65535)) - 32768;
                        m = pv + (sp - pv) / 8 + int'($urandom_range(0, 200)) - 100;
                        if (m > 32767)
                            m = 32767;
                        if (m < -32768)
                            m = -32768;
                        pv = m;
                        r = 16'(sp);
                        f = 16'(pv);
                    end
                endcase
                send_item(op, r, f, 1'b0, '0);
                done_random++;
            end
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side: check, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        ctrl_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_q.size() == 0)
            begin
                $error("unexpected transaction: drive=%0d saturated=%0b", drive, saturated);
                errors++;
            end
            else
            begin
                want = drive_q.pop_front();
                if (drive !== want.drive)
                begin
                    $error("drive: expected %0d, got %0d", want.drive, drive);
                    errors++;
                end
                if (saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", want.saturated, saturated);
                    errors++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && in_valid && items_sent >= 500)
        begin
            // long back-pressure so the input side backs up too
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(0, 99) < 24);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

// File: files.f
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_regs.sv
hw/rtl/pfd_ctrl.sv
hw/rtl/pfd_dp.sv
hw/rtl/pid_filtered_derivative.sv
bench/tb_pid_filtered_derivative.sv
